/* rtl/tli_pkg.sv */
// Shared types and constants of the trajectory interpolator.
`timescale 1ns / 1ps
package tli_pkg;

  localparam int TLI_TABLE_DEPTH = 1024;
  localparam int TLI_VW          = 48;
  localparam int TLI_NCOMP       = 6;
  localparam int TLI_REVW        = 16;
  localparam int TLI_SPW         = 33;
  localparam int TLI_FRAC        = 28;

  localparam logic [TLI_SPW-1:0] TLI_SPACING_RST = 33'd65536;
  localparam logic [31:0]        TLI_WMAX        = 32'hFFFF_FFFF;
  localparam logic [31:0]        TLI_ONE         = 32'h1000_0000;
  localparam logic [5:0]         TLI_IDX_STEPS   = 6'd48;
  localparam logic [5:0]         TLI_FAC_STEPS   = 6'd32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } tli_op_t;

  typedef struct packed {
    tli_op_t          op;
    logic [47:0]      stime;
    logic [5:0][47:0] comp;
    logic [15:0]      rev;
  } tli_item_t;

  typedef struct packed {
    logic        start;
    logic [47:0] p_init;
    logic [47:0] sh_init;
    logic [47:0] den;
    logic [5:0]  steps;
  } tli_div_req_t;

endpackage

/* rtl/tli_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tli_ram #(
  parameter int W     = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/tli_front.sv */
// Front end: accepts input words, drops unknown operations, queues the rest.
`timescale 1ns / 1ps
module tli_front import tli_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [47:0] in_sample_time,
  input  logic [47:0] in_pos_x,
  input  logic [47:0] in_pos_y,
  input  logic [47:0] in_pos_z,
  input  logic [47:0] in_vel_x,
  input  logic [47:0] in_vel_y,
  input  logic [47:0] in_vel_z,
  input  logic [15:0] in_revolutions_in,
  output logic        q_valid,
  output tli_item_t   q_item,
  input  logic        q_pop
);

  tli_item_t slot_r [2];
  logic      wr_ptr_r;
  logic      rd_ptr_r;
  logic [1:0] fill_r;
  logic      accept;
  logic      keep;
  logic      push;
  logic      pop;
  tli_item_t item;

  assign in_stall = (fill_r == 2'd2);
  assign accept   = in_valid && !in_stall;

  // classify the operation code
  always_comb begin
    case (in_operation)
      OP_CLEAR, OP_APPEND, OP_QUERY: keep = 1'b1;
      default:                       keep = 1'b0;
    endcase
  end

  always_comb begin
    item.op    = tli_op_t'(in_operation);
    item.stime = in_sample_time;
    item.comp  = {in_vel_z, in_vel_y, in_vel_x, in_pos_z, in_pos_y, in_pos_x};
    item.rev   = in_revolutions_in;
  end

  assign push    = accept && keep;
  assign q_valid = (fill_r != 2'd0);
  assign pop     = q_pop && q_valid;
  assign q_item  = slot_r[rd_ptr_r];

  // advance the two-entry queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= item;
        wr_ptr_r         <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'd2) |=> !(fill_r == 2'd0))
    else $error("queue emptied from full in one cycle");

endmodule

/* rtl/tli_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tli_div import tli_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  tli_div_req_t req,
  output logic         done,
  output logic [47:0]  quot
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [47:0] p_r;
  logic [47:0] sh_r;
  logic [47:0] den_r;
  logic [47:0] q_r;
  logic [48:0] p2;
  logic [48:0] pdiff;
  logic        ge;

  // one trial subtraction
  assign p2    = {p_r, sh_r[47]};
  assign pdiff = p2 - {1'b0, den_r};
  assign ge    = (p2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
        p_r    <= req.p_init;
        sh_r   <= req.sh_init;
        den_r  <= req.den;
        q_r    <= '0;
      end else if (busy_r) begin
        p_r   <= ge ? pdiff[47:0] : p2[47:0];
        sh_r  <= {sh_r[46:0], 1'b0};
        q_r   <= {q_r[46:0], ge};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

/* rtl/tli_back.sv */
// Back end: sample table, index search, Lagrange weights and weighted sums.
`timescale 1ns / 1ps
module tli_back import tli_pkg::*; #(
  parameter int TABLE_DEPTH = TLI_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [32:0]        cfg_wdata,
  input  logic               q_valid,
  input  tli_item_t          q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic signed [47:0] out_pos_x,
  output logic signed [47:0] out_pos_y,
  output logic signed [47:0] out_pos_z,
  output logic signed [47:0] out_vel_x,
  output logic signed [47:0] out_vel_y,
  output logic signed [47:0] out_vel_z,
  output logic [15:0]        out_revolutions_out
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic signed [54:0] SUM_MAX = 55'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [54:0] SUM_MIN = -55'sh0_8000_0000_0000;
  localparam logic [64:0] RND = 65'h800_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_T0, S_T0W, S_IDIV, S_IDX, S_RDNEAR, S_NEARW, S_RDT, S_RDTW,
    S_FAC, S_FDIV, S_WMUL, S_WRND, S_MNEXT, S_RDROW, S_ROWW, S_TLO, S_THI,
    S_TACC, S_SAT, S_DONE
  } state_t;

  state_t              state_r;
  logic [32:0]         spacing_r;
  logic [CW-1:0]       cnt_r;
  logic [47:0]         t_r;
  logic [AW-1:0]       idx_r;
  logic [AW-1:0]       first_r;
  logic                near_neg_r;
  logic [15:0]         rev_r;
  logic [47:0]         tt_r [4];
  logic [1:0]          k_r;
  logic [1:0]          n_r;
  logic [1:0]          m_r;
  logic [2:0]          c_r;
  logic [31:0]         acc_r;
  logic                sg_r;
  logic [31:0]         f_r;
  logic                fneg_r;
  logic [31:0]         w_r [4];
  logic                wneg_r [4];
  logic [47:0]         v_r [6];
  logic [63:0]         prod_r;
  logic [63:0]         lo_r;
  logic signed [54:0]  sum_r [6];
  logic                res_found_r;
  logic [47:0]         res_val_r [6];
  logic [15:0]         res_rev_r;
  logic                out_valid_r;
  logic                out_found_r;
  logic [47:0]         out_val_r [6];
  logic [15:0]         out_rev_r;

  // table memories
  logic                ram_we;
  logic [AW-1:0]       rd_addr;
  logic [47:0]         t_rdata;
  logic [15:0]         r_rdata;
  logic [47:0]         c_rdata [6];

  assign q_pop  = (state_r == S_IDLE) && q_valid;
  assign ram_we = q_pop && (q_item.op == OP_APPEND) && (cnt_r < CW'(TABLE_DEPTH));

  // select the table row to read
  always_comb begin
    case (state_r)
      S_RDNEAR: rd_addr = idx_r;
      S_RDT:    rd_addr = first_r + AW'(k_r);
      S_RDROW:  rd_addr = first_r + AW'(n_r);
      default:  rd_addr = '0;
    endcase
  end

  tli_ram #(.W(48), .DEPTH(TABLE_DEPTH)) u_time_ram (
    .clk(clk), .we(ram_we), .waddr(cnt_r[AW-1:0]), .wdata(q_item.stime),
    .raddr(rd_addr), .rdata(t_rdata)
  );

  tli_ram #(.W(16), .DEPTH(TABLE_DEPTH)) u_rev_ram (
    .clk(clk), .we(ram_we), .waddr(cnt_r[AW-1:0]), .wdata(q_item.rev),
    .raddr(rd_addr), .rdata(r_rdata)
  );

  for (genvar g = 0; g < 6; g++) begin : g_comp
    tli_ram #(.W(48), .DEPTH(TABLE_DEPTH)) u_comp_ram (
      .clk(clk), .we(ram_we), .waddr(cnt_r[AW-1:0]), .wdata(q_item.comp[g]),
      .raddr(rd_addr), .rdata(c_rdata[g])
    );
  end

  // Lagrange factor operands
  logic [47:0] tm;
  logic [47:0] tn;
  logic [48:0] num;
  logic [48:0] den;
  logic [48:0] num_neg;
  logic [48:0] den_neg;
  logic [47:0] ua;
  logic [47:0] ub;
  logic        f_ovf;
  logic        fac_div;

  assign tm      = tt_r[m_r];
  assign tn      = tt_r[n_r];
  assign num     = {1'b0, t_r} - {1'b0, tm};
  assign den     = {1'b0, tn} - {1'b0, tm};
  assign num_neg = -num;
  assign den_neg = -den;
  assign ua      = num[48] ? num_neg[47:0] : num[47:0];
  assign ub      = den[48] ? den_neg[47:0] : den[47:0];
  assign f_ovf   = ({4'b0, ua} >= {ub, 4'b0});
  assign fac_div = (m_r != n_r) && (ua != 48'd0) && (ub != 48'd0) && !f_ovf;

  // shared divider
  tli_div_req_t dv_req;
  logic         dv_done;
  logic [47:0]  dv_quot;
  logic [47:0]  t_off;

  assign t_off = t_r - t_rdata;

  always_comb begin
    dv_req.start = ((state_r == S_T0W) && !(t_r < t_rdata)) ||
                   ((state_r == S_FAC) && fac_div);
    if (state_r == S_FAC) begin
      dv_req.p_init  = {4'b0, ua[47:4]};
      dv_req.sh_init = {ua[3:0], 44'b0};
      dv_req.den     = ub;
      dv_req.steps   = TLI_FAC_STEPS;
    end else begin
      dv_req.p_init  = '0;
      dv_req.sh_init = t_off;
      dv_req.den     = {15'b0, spacing_r};
      dv_req.steps   = TLI_IDX_STEPS;
    end
  end

  tli_div u_div (
    .clk(clk), .rst_n(rst_n), .req(dv_req), .done(dv_done), .quot(dv_quot)
  );

  // index and window start
  logic [AW-1:0] idx_new;
  logic [AW-1:0] fst;
  logic [AW-1:0] lim;
  logic [CW-1:0] cnt_m4;
  logic          out_range;

  assign out_range = (dv_quot >= 48'(cnt_r));
  assign idx_new   = dv_quot[AW-1:0];
  assign cnt_m4    = cnt_r - CW'(4);
  assign lim       = cnt_m4[AW-1:0];

  always_comb begin
    if (idx_new < AW'(2)) begin
      fst = '0;
    end else begin
      fst = idx_new - AW'(2);
    end
    if (fst > lim) begin
      fst = lim;
    end
  end

  // shared multiplier operands
  logic [47:0] v_cur;
  logic        vneg;
  logic [47:0] vm;
  logic [31:0] w_cur;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  assign v_cur = v_r[c_r];
  assign vneg  = v_cur[47];
  assign vm    = vneg ? (~v_cur + 48'd1) : v_cur;
  assign w_cur = w_r[n_r];

  always_comb begin
    case (state_r)
      S_WMUL: begin
        mul_a = acc_r;
        mul_b = f_r;
      end
      S_THI: begin
        mul_a = w_cur;
        mul_b = {16'b0, vm[47:32]};
      end
      default: begin
        mul_a = w_cur;
        mul_b = vm[31:0];
      end
    endcase
  end

  // rounding of weight products and terms
  logic [64:0] wsum;
  logic [64:0] lsum;
  logic [31:0] acc_nxt;
  logic [52:0] term;
  logic        tneg;

  assign wsum    = {1'b0, prod_r} + RND;
  assign lsum    = {1'b0, lo_r} + RND;
  assign acc_nxt = (wsum[64:28] > 37'h0_FFFF_FFFF) ? TLI_WMAX : wsum[59:28];
  assign term    = 53'({prod_r[47:0], 4'b0}) + 53'(lsum[64:28]);
  assign tneg    = vneg ^ wneg_r[n_r];

  // saturate the sums
  logic [47:0] sat_val [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      if (sum_r[i] > SUM_MAX) begin
        sat_val[i] = 48'h7FFF_FFFF_FFFF;
      end else if (sum_r[i] < SUM_MIN) begin
        sat_val[i] = 48'h8000_0000_0000;
      end else begin
        sat_val[i] = sum_r[i][47:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spacing_r   <= TLI_SPACING_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        spacing_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.op)
              OP_CLEAR: cnt_r <= '0;
              OP_APPEND: begin
                if (ram_we) begin
                  cnt_r <= cnt_r + CW'(1);
                end
              end
              OP_QUERY: begin
                t_r <= q_item.stime;
                if ((cnt_r < CW'(4)) || (spacing_r == 33'd0)) begin
                  res_found_r <= 1'b0;
                  res_rev_r   <= '0;
                  for (int i = 0; i < 6; i++) res_val_r[i] <= '0;
                  state_r     <= S_DONE;
                end else begin
                  state_r <= S_T0;
                end
              end
              default: ;
            endcase
          end
        end
        S_T0: state_r <= S_T0W;
        S_T0W: begin
          if (t_r < t_rdata) begin
            res_found_r <= 1'b0;
            res_rev_r   <= '0;
            for (int i = 0; i < 6; i++) res_val_r[i] <= '0;
            state_r     <= S_DONE;
          end else begin
            state_r <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (dv_done) begin
            state_r <= S_IDX;
          end
        end
        S_IDX: begin
          if (out_range) begin
            res_found_r <= 1'b0;
            res_rev_r   <= '0;
            for (int i = 0; i < 6; i++) res_val_r[i] <= '0;
            state_r     <= S_DONE;
          end else begin
            idx_r   <= idx_new;
            first_r <= fst;
            state_r <= S_RDNEAR;
          end
        end
        S_RDNEAR: state_r <= S_NEARW;
        S_NEARW: begin
          near_neg_r <= c_rdata[2][47];
          rev_r      <= r_rdata;
          k_r        <= 2'd0;
          state_r    <= S_RDT;
        end
        S_RDT: state_r <= S_RDTW;
        S_RDTW: begin
          tt_r[k_r] <= t_rdata;
          if (k_r == 2'd3) begin
            n_r     <= 2'd0;
            m_r     <= 2'd0;
            acc_r   <= TLI_ONE;
            sg_r    <= 1'b0;
            state_r <= S_FAC;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_RDT;
          end
        end
        S_FAC: begin
          if (m_r == n_r) begin
            state_r <= S_MNEXT;
          end else if (ua == 48'd0) begin
            f_r     <= '0;
            fneg_r  <= 1'b0;
            state_r <= S_WMUL;
          end else if ((ub == 48'd0) || f_ovf) begin
            f_r     <= TLI_WMAX;
            fneg_r  <= num[48] ^ den[48];
            state_r <= S_WMUL;
          end else begin
            fneg_r  <= num[48] ^ den[48];
            state_r <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (dv_done) begin
            f_r     <= dv_quot[31:0];
            state_r <= S_WMUL;
          end
        end
        S_WMUL: state_r <= S_WRND;
        S_WRND: begin
          acc_r   <= acc_nxt;
          sg_r    <= sg_r ^ fneg_r;
          state_r <= S_MNEXT;
        end
        S_MNEXT: begin
          if (m_r == 2'd3) begin
            w_r[n_r]    <= acc_r;
            wneg_r[n_r] <= sg_r;
            if (n_r == 2'd3) begin
              n_r <= 2'd0;
              for (int i = 0; i < 6; i++) sum_r[i] <= '0;
              state_r <= S_RDROW;
            end else begin
              n_r     <= n_r + 2'd1;
              m_r     <= 2'd0;
              acc_r   <= TLI_ONE;
              sg_r    <= 1'b0;
              state_r <= S_FAC;
            end
          end else begin
            m_r     <= m_r + 2'd1;
            state_r <= S_FAC;
          end
        end
        S_RDROW: state_r <= S_ROWW;
        S_ROWW: begin
          for (int i = 0; i < 6; i++) v_r[i] <= c_rdata[i];
          c_r     <= 3'd0;
          state_r <= S_TLO;
        end
        S_TLO: state_r <= S_THI;
        S_THI: begin
          lo_r    <= prod_r;
          state_r <= S_TACC;
        end
        S_TACC: begin
          if (tneg) begin
            sum_r[c_r] <= sum_r[c_r] - $signed(55'(term));
          end else begin
            sum_r[c_r] <= sum_r[c_r] + $signed(55'(term));
          end
          if (c_r == 3'd5) begin
            if (n_r == 2'd3) begin
              state_r <= S_SAT;
            end else begin
              n_r     <= n_r + 2'd1;
              state_r <= S_RDROW;
            end
          end else begin
            c_r     <= c_r + 3'd1;
            state_r <= S_TLO;
          end
        end
        S_SAT: begin
          res_found_r <= 1'b1;
          for (int i = 0; i < 6; i++) res_val_r[i] <= sat_val[i];
          res_rev_r   <= rev_r + 16'(near_neg_r && !sat_val[2][47]);
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            for (int i = 0; i < 6; i++) out_val_r[i] <= res_val_r[i];
            out_rev_r   <= res_rev_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_pos_x           = out_val_r[0];
  assign out_pos_y           = out_val_r[1];
  assign out_pos_z           = out_val_r[2];
  assign out_vel_x           = out_val_r[3];
  assign out_vel_y           = out_val_r[4];
  assign out_vel_z           = out_val_r[5];
  assign out_revolutions_out = out_rev_r;

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("sample count beyond table depth");

  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_rev_r == 16'd0) && (out_val_r[2] == 48'd0))
    else $error("not-found word carries data");

endmodule

/* rtl/trajectory_lagrange_interpolator.sv */
// A query uses the shared bit-serial divider for one 48-bit index division and
// up to twelve 32-bit factor divisions, one bit a cycle.
// Clear and append are done in the back end when popped from the two-word input queue.
// One query is worked at a time; meanwhile the queue takes up to two words, then stalls.
// Synchronous active-low reset empties the table and sets spacing to 1.0 s;
// table memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module trajectory_lagrange_interpolator import tli_pkg::*; #(
  parameter int TABLE_DEPTH = TLI_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [32:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [47:0]        in_sample_time,
  input  logic signed [47:0] in_pos_x,
  input  logic signed [47:0] in_pos_y,
  input  logic signed [47:0] in_pos_z,
  input  logic signed [47:0] in_vel_x,
  input  logic signed [47:0] in_vel_y,
  input  logic signed [47:0] in_vel_z,
  input  logic [15:0]        in_revolutions_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic signed [47:0] out_pos_x,
  output logic signed [47:0] out_pos_y,
  output logic signed [47:0] out_pos_z,
  output logic signed [47:0] out_vel_x,
  output logic signed [47:0] out_vel_y,
  output logic signed [47:0] out_vel_z,
  output logic [15:0]        out_revolutions_out
);

  logic      q_valid;
  logic      q_pop;
  tli_item_t q_item;

  tli_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_sample_time(in_sample_time),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .in_revolutions_in(in_revolutions_in),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  tli_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_vel_z(out_vel_z),
    .out_revolutions_out(out_revolutions_out)
  );

endmodule
